/* hw/rtl/mirl_pkg.sv */
// Shared types, constants and helpers for the metric index raise/lower unit.
// No dependencies; the interfaces, sequencer, datapath and top level use this package.
package mirl_pkg;

  localparam int unsigned MaxRank  = 3;
  localparam int unsigned ValW     = 32;
  localparam int unsigned PosW     = 4;
  localparam int unsigned DigW     = 2;
  localparam int unsigned FracBits = 16;
  localparam int unsigned AccW     = 66;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRaisedPos = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDimsUsed  = 1'b1;

  localparam logic [DigW-1:0] DimsReset = 2'd3;

  // input item opcodes
  localparam logic OpMetric = 1'b0;
  localparam logic OpTensor = 1'b1;

  typedef enum logic [1:0] {
    StLoad,
    StIssue,
    StDrain,
    StEmit
  } ctrl_state_e;

  typedef struct packed {
    logic load;   // input transfer this cycle
    logic start;  // transfer carries the last flag
    logic issue;  // read one metric/tensor pair
    logic emit;   // move finished sum to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic j_last;
    logic elem_last;
    logic acc_done;
    logic out_free;
  } dp_status_t;

  // small integer power, base <= 3, exponent <= MaxRank
  function automatic logic [4:0] pow_small(logic [DigW-1:0] base, logic [1:0] expo);
    logic [4:0] r;
    r = 5'd1;
    for (int k = 0; k < MaxRank; k++) begin
      if (k < int'(expo)) begin
        r = 5'(r * 5'(base));
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/mirl_if.sv */
// Stream channel interfaces for the metric index raise/lower unit.
// Depends on mirl_pkg for field widths.
interface mirl_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [mirl_pkg::ValW-1:0]  in_value;
  logic                              in_last;

  modport source (output valid, output op, output in_value, output in_last, input ready);
  modport sink   (input valid, input op, input in_value, input in_last, output ready);
endinterface

interface mirl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mirl_pkg::ValW-1:0]  out_value;
  logic        [mirl_pkg::PosW-1:0]  out_position;
  logic                              out_last;

  modport source (output valid, output out_value, output out_position, output out_last,
                  input ready);
  modport sink   (input valid, input out_value, input out_position, input out_last,
                  output ready);
endinterface

/* hw/rtl/mirl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mirl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 9,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mirl_ctrl.sv */
// Sequencer for the metric index raise/lower unit: load, issue, drain, emit.
// Depends on mirl_pkg for the state enum and command/status structs.
module mirl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  mirl_pkg::dp_status_t status_i,
  output mirl_pkg::dp_cmd_t    cmd_o
);

  mirl_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mirl_pkg::StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mirl_pkg::StLoad: begin
        if (in_valid_i && in_last_i) state_d = mirl_pkg::StIssue;
      end
      mirl_pkg::StIssue: begin
        if (status_i.j_last) state_d = mirl_pkg::StDrain;
      end
      mirl_pkg::StDrain: begin
        if (status_i.acc_done) state_d = mirl_pkg::StEmit;
      end
      mirl_pkg::StEmit: begin
        if (status_i.out_free) begin
          state_d = status_i.elem_last ? mirl_pkg::StLoad : mirl_pkg::StIssue;
        end
      end
      default: state_d = mirl_pkg::StLoad;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == mirl_pkg::StLoad);
    cmd_o.load  = in_ready_o && in_valid_i;
    cmd_o.start = cmd_o.load && in_last_i;
    cmd_o.issue = (state_q == mirl_pkg::StIssue);
    cmd_o.emit  = (state_q == mirl_pkg::StEmit) && status_i.out_free;
  end

endmodule

/* hw/rtl/mirl_dp.sv */
// Datapath: config registers, metric/tensor stores, index counters, MAC and output register.
// Depends on mirl_pkg and mirl_ram.
module mirl_dp #(
  parameter int unsigned DIM  = 3,
  parameter int unsigned RANK = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mirl_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mirl_pkg::CfgDataW-1:0]       cfg_data_i,
  input  mirl_pkg::dp_cmd_t                   cmd_i,
  output mirl_pkg::dp_status_t                status_o,
  input  logic                                op_i,
  input  logic signed [mirl_pkg::ValW-1:0]    in_value_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [mirl_pkg::ValW-1:0]    out_value_o,
  output logic [mirl_pkg::PosW-1:0]           out_position_o,
  output logic                                out_last_o
);

  localparam int unsigned MSize = DIM * DIM;
  localparam int unsigned TSize = DIM ** RANK;
  localparam int unsigned MAW   = (MSize > 1) ? $clog2(MSize) : 1;
  localparam int unsigned TAW   = (TSize > 1) ? $clog2(TSize) : 1;
  localparam int unsigned MCW   = $clog2(MSize + 1);
  localparam int unsigned TCW   = $clog2(TSize + 1);
  localparam int unsigned RIW   = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int unsigned ShrW  = mirl_pkg::AccW - mirl_pkg::FracBits;
  localparam int unsigned DW    = mirl_pkg::DigW;
  localparam int unsigned VW    = mirl_pkg::ValW;

  // configuration
  logic          rp_q;
  logic [DW-1:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= 1'b0;
      dims_q <= mirl_pkg::DimsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mirl_pkg::CfgRaisedPos: rp_q   <= cfg_data_i[0];
        mirl_pkg::CfgDimsUsed:  dims_q <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions and position, derived sizes
  logic [DW-1:0]  n_eff;
  logic [RIW-1:0] rp_eff;
  logic [4:0]     msize, tsize, stride;

  always_comb begin
    if (dims_q == '0)                n_eff = DW'(1);
    else if (int'(dims_q) > DIM)     n_eff = DW'(DIM);
    else                             n_eff = dims_q;
    if (int'(rp_q) >= RANK)          rp_eff = RIW'(RANK - 1);
    else                             rp_eff = RIW'(rp_q);
    msize  = mirl_pkg::pow_small(n_eff, 2'd2);
    tsize  = mirl_pkg::pow_small(n_eff, 2'(RANK));
    stride = mirl_pkg::pow_small(n_eff, 2'(RANK - 1) - 2'(rp_eff));
  end

  // store fill counts
  logic [MCW-1:0] mcount_q;
  logic [TCW-1:0] tcount_q;
  logic           m_we, t_we;

  assign m_we = cmd_i.load && (op_i == mirl_pkg::OpMetric) && (5'(mcount_q) < msize);
  assign t_we = cmd_i.load && (op_i == mirl_pkg::OpTensor) && (5'(tcount_q) < tsize);

  // output element and contraction counters
  logic [TAW-1:0] p_q;
  logic [DW-1:0]  j_q;
  logic [DW-1:0]  idx_q [RANK];
  logic [DW-1:0]  idx_nxt [RANK];
  logic [DW-1:0]  a_dig;
  logic           j_last, elem_last;

  assign a_dig     = idx_q[rp_eff];
  assign j_last    = (j_q == DW'(n_eff - DW'(1)));
  assign elem_last = (6'(p_q) == 6'(tsize) - 6'd1);

  // odometer step over the row-major indexes
  always_comb begin
    logic carry;
    carry   = 1'b1;
    idx_nxt = idx_q;
    for (int k = RANK - 1; k >= 0; k--) begin
      if (carry) begin
        if (idx_q[k] == DW'(n_eff - DW'(1))) begin
          idx_nxt[k] = '0;
        end else begin
          idx_nxt[k] = idx_q[k] + DW'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcount_q <= '0;
      tcount_q <= '0;
      p_q      <= '0;
      j_q      <= '0;
      idx_q    <= '{default: '0};
    end else begin
      if (m_we) mcount_q <= mcount_q + MCW'(1);
      if (t_we) tcount_q <= tcount_q + TCW'(1);
      if (cmd_i.emit && elem_last) begin
        mcount_q <= '0;
        tcount_q <= '0;
      end
      if (cmd_i.start) begin
        p_q   <= '0;
        j_q   <= '0;
        idx_q <= '{default: '0};
      end else begin
        if (cmd_i.issue) j_q <= j_last ? '0 : j_q + DW'(1);
        if (cmd_i.emit) begin
          p_q   <= p_q + TAW'(1);
          idx_q <= idx_nxt;
        end
      end
    end
  end

  // read addresses: metric[a][j], tensor[p - a*stride + j*stride]
  logic [3:0]     m_addr_w;
  logic [5:0]     t_addr_w;
  logic [VW-1:0]  m_rdata, t_rdata;

  assign m_addr_w = 4'(a_dig) * 4'(n_eff) + 4'(j_q);
  assign t_addr_w = 6'(p_q) - 6'(a_dig) * 6'(stride) + 6'(j_q) * 6'(stride);

  mirl_ram #(.Width(VW), .Depth(MSize)) u_metric_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (MAW'(mcount_q)),
    .wdata_i (in_value_i),
    .raddr_i (MAW'(m_addr_w)),
    .rdata_o (m_rdata)
  );

  mirl_ram #(.Width(VW), .Depth(TSize)) u_tensor_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (TAW'(tcount_q)),
    .wdata_i (in_value_i),
    .raddr_i (TAW'(t_addr_w)),
    .rdata_o (t_rdata)
  );

  // MAC pipeline: read data -> product -> accumulate
  logic                          v1_q, f1_q, l1_q, v2_q, f2_q, l2_q, done_q;
  logic signed [2*VW-1:0]        prod_q;
  logic signed [mirl_pkg::AccW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      f1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      f2_q   <= 1'b0;
      l2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= cmd_i.issue;
      f1_q   <= cmd_i.issue && (j_q == '0);
      l1_q   <= cmd_i.issue && j_last;
      v2_q   <= v1_q;
      f2_q   <= f1_q;
      l2_q   <= l1_q;
      done_q <= v2_q && l2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(m_rdata) * $signed(t_rdata);
    if (v2_q) begin
      acc_q <= (f2_q ? '0 : acc_q) + mirl_pkg::AccW'(prod_q);
    end
  end

  // floor shift by the fraction width, then saturate
  logic signed [ShrW-1:0] shr;
  logic [ShrW-VW:0]       shr_top;
  logic [VW-1:0]          sat_val;

  assign shr     = acc_q[mirl_pkg::AccW-1:mirl_pkg::FracBits];
  assign shr_top = shr[ShrW-1:VW-1];

  always_comb begin
    if ((&shr_top) || !(|shr_top)) sat_val = shr[VW-1:0];
    else if (shr[ShrW-1])          sat_val = {1'b1, {(VW-1){1'b0}}};
    else                           sat_val = {1'b0, {(VW-1){1'b1}}};
  end

  // output register
  logic                   out_valid_q;
  logic signed [VW-1:0]   out_value_q;
  logic [mirl_pkg::PosW-1:0] out_pos_q;
  logic                   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= $signed(sat_val);
      out_pos_q   <= mirl_pkg::PosW'(p_q);
      out_last_q  <= elem_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_position_o = out_pos_q;
  assign out_last_o     = out_last_q;

  assign status_o.j_last    = j_last;
  assign status_o.elem_last = elem_last;
  assign status_o.acc_done  = done_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

/* hw/rtl/metric_index_raise_lower_unit.sv */
// Top level of the metric index raise/lower unit.
// Depends on mirl_pkg, mirl_if, mirl_ram, mirl_ctrl and mirl_dp.

// Raises or lowers one index of a rank-RANK tensor with a metric, one grid point at a
// time. Send the n*n metric elements (op 0) and the n^RANK tensor elements (op 1) in
// row-major order, one per cycle; elements past a full store are dropped. The transfer
// with in_last set starts the contraction, and input is held off until every output
// element has been computed. Each output element is the sum over j of metric[a][j]
// times the tensor element with index j at the raised position, computed on a single
// 32x32 multiplier: one metric/tensor pair is read per j, each pair passes through the
// read, product and accumulate registers, and the saturated Q16.16 result is handed to
// the output register once that register is free. The next element computes while the
// previous one waits in the output register. Configuration (raised_position, dims_used)
// may only be written while the unit is idle; out-of-range values are clamped.
module metric_index_raise_lower_unit #(
  parameter int unsigned DIM  = 3,
  parameter int unsigned RANK = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mirl_in_if.sink                       in_ch_i,
  mirl_out_if.source                    out_ch_o,
  input  logic                          cfg_we_i,
  input  logic [mirl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mirl_pkg::CfgDataW-1:0] cfg_data_i
);

  mirl_pkg::dp_cmd_t    cmd;
  mirl_pkg::dp_status_t status;

  // sequencer: owns input ready and paces the MAC
  mirl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_last_i  (in_ch_i.in_last),
    .in_ready_o (in_ch_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // stores, counters, MAC and output register
  mirl_dp #(.DIM(DIM), .RANK(RANK)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (in_ch_i.op),
    .in_value_i     (in_ch_i.in_value),
    .out_ready_i    (out_ch_o.ready),
    .out_valid_o    (out_ch_o.valid),
    .out_value_o    (out_ch_o.out_value),
    .out_position_o (out_ch_o.out_position),
    .out_last_o     (out_ch_o.out_last)
  );

  // a last-flagged transfer must close the input side for the contraction
  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch_i.valid && in_ch_i.ready && in_ch_i.in_last |=> !in_ch_i.ready)
    else $error("input still open after last transfer");

  // the accumulator finishes only while the input side is closed
  a_acc_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.acc_done |-> !in_ch_i.ready)
    else $error("sum completed while loading");

  // a result never overwrites one that has not been transferred
  a_emit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("output register overwritten");

  // handing off the final element reopens the input side
  a_final_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && status.elem_last |=> in_ch_i.ready)
    else $error("input not reopened after final element");

endmodule
